// File: rtl/core/linear_gradient_pixel_blend_macros.svh
// Assertion helpers used by the blend pipeline control
`ifndef LINEAR_GRADIENT_PIXEL_BLEND_MACROS_SVH
`define LINEAR_GRADIENT_PIXEL_BLEND_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define LGPB_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("lgpb assertion failed");

// Check a consequence in the cycle after its cause
`define LGPB_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("lgpb assertion failed");

`endif

// File: rtl/core/lgpb_pkg.sv
package lgpb_pkg;

  localparam int COL_W       = 12;
  localparam int PIX_W       = 8;
  localparam int QUO_W       = 8;
  localparam int NUM_LANES   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int MODE_W      = 2;
  localparam int RESET_WIDTH = 256;
  // product stage, sum stage, then one stage per quotient bit
  localparam int NUM_STAGES  = 2 + QUO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_RED   = 3'd0,
    REG_START_GREEN = 3'd1,
    REG_START_BLUE  = 3'd2,
    REG_END_RED     = 3'd3,
    REG_END_GREEN   = 3'd4,
    REG_END_BLUE    = 3'd5,
    REG_BLEND_MODE  = 3'd6,
    REG_IMAGE_WIDTH = 3'd7
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET  = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_DIFF = 2'd2
  } blend_mode_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] pixel_in_red;
    logic [PIX_W-1:0] pixel_in_green;
    logic [PIX_W-1:0] pixel_in_blue;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out_red;
    logic [PIX_W-1:0] pixel_out_green;
    logic [PIX_W-1:0] pixel_out_blue;
  } out_word_t;

  // floor and ceiling of the gradient value plus the pixel it applies to
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] pix;
  } lane_res_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] stage_en;
    logic                  out_en;
  } pipe_ctrl_t;

endpackage

// File: rtl/core/lgpb_ctrl.sv
`include "linear_gradient_pixel_blend_macros.svh"

module lgpb_ctrl import lgpb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output pipe_ctrl_t ctl
);

  localparam int CNT_W = $clog2(NUM_STAGES + 2);

  logic [NUM_STAGES-1:0] vld_r, vld_nxt, vld_in;
  logic                  out_valid_r, out_valid_nxt;
  logic [NUM_STAGES:0]   adv;

  // a stage loads when it is empty or the stage after it loads
  always_comb begin
    adv[NUM_STAGES] = !out_valid_r || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  // advance valid bits where the stage loads, hold elsewhere
  assign vld_in = {vld_r[NUM_STAGES-2:0], in_valid};

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      vld_nxt[k] = adv[k] ? vld_in[k] : vld_r[k];
    end
    out_valid_nxt = adv[NUM_STAGES] ? vld_r[NUM_STAGES-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall     = !adv[0];
  assign out_valid    = out_valid_r;
  assign ctl.stage_en = adv[NUM_STAGES-1:0];
  assign ctl.out_en   = adv[NUM_STAGES];

  // occupancy bookkeeping for the checks below
  logic             in_acc, out_acc;
  logic [CNT_W-1:0] occ, occ_exp;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign occ     = CNT_W'($countones({vld_r, out_valid_r}));
  assign occ_exp = occ + CNT_W'(in_acc) - CNT_W'(out_acc);

  `LGPB_ASSERT_NEXT(a_occupancy, clk, rst_n, 1'b1, occ == $past(occ_exp))
  `LGPB_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, (&vld_r) && out_valid_r && out_stall)
  `LGPB_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid_r), $past(vld_r[NUM_STAGES-1]))

endmodule

// File: rtl/core/lgpb_lane.sv
module lgpb_lane import lgpb_pkg::*; #(
  parameter int DEN_W = 12
) (
  input  logic                  clk,
  input  logic [NUM_STAGES-1:0] stage_en,
  input  logic [PIX_W-1:0]      grad_start,
  input  logic [PIX_W-1:0]      grad_stop,
  input  logic [DEN_W-1:0]      den_eff,
  input  logic [DEN_W-1:0]      col_sat,
  input  logic [PIX_W-1:0]      pix_in,
  output lane_res_t             res
);

  localparam int NUM_W  = DEN_W + PIX_W;
  localparam int PROD_W = DEN_W + PIX_W + 2;

  logic [NUM_W-1:0]         prod_base_r;
  logic signed [PROD_W-1:0] prod_ramp_r;
  logic signed [PIX_W:0]    diff;
  logic signed [PROD_W-1:0] num_sum;
  logic [NUM_W-1:0]         rem_r [QUO_W+1];
  logic [QUO_W-1:0]         q_r   [QUO_W+1];
  logic [PIX_W-1:0]         pix_r [NUM_STAGES];

  // products: start*den and column*(end-start)
  assign diff = $signed({1'b0, grad_stop}) - $signed({1'b0, grad_start});

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      prod_base_r <= NUM_W'(grad_start) * NUM_W'(den_eff);
      prod_ramp_r <= PROD_W'(diff) * PROD_W'($signed({1'b0, col_sat}));
      pix_r[0]    <= pix_in;
    end
  end

  // numerator, never negative since the column is at most the denominator
  assign num_sum = $signed({2'b00, prod_base_r}) + prod_ramp_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      rem_r[0] <= num_sum[NUM_W-1:0];
      q_r[0]   <= '0;
      pix_r[1] <= pix_r[0];
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_div
    logic [NUM_W-1:0] divisor;
    logic [NUM_W:0]   trial;

    assign divisor = NUM_W'(den_eff) << (QUO_W - j);
    assign trial   = {1'b0, rem_r[j-1]} - {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (stage_en[j+1]) begin
        if (!trial[NUM_W]) begin
          rem_r[j] <= trial[NUM_W-1:0];
          q_r[j]   <= {q_r[j-1][QUO_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= {q_r[j-1][QUO_W-2:0], 1'b0};
        end
        pix_r[j+1] <= pix_r[j];
      end
    end
  end

  // ceiling is floor plus one when the remainder is nonzero
  assign res.lo  = q_r[QUO_W];
  assign res.hi  = q_r[QUO_W] + PIX_W'(rem_r[QUO_W] != '0);
  assign res.pix = pix_r[NUM_STAGES-1];

endmodule

// File: rtl/core/lgpb_merge.sv
module lgpb_merge import lgpb_pkg::*; (
  input  logic                            clk,
  input  logic                            out_en,
  input  logic [MODE_W-1:0]               mode,
  input  lane_res_t [NUM_LANES-1:0]       res,
  output out_word_t                       out_data
);

  logic [PIX_W-1:0] blend [NUM_LANES];
  out_word_t        out_r;

  // apply the blend mode per channel; the unused code behaves as set
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      unique case (mode)
        MODE_SUM:  blend[i] = res[i].pix + res[i].lo;
        MODE_DIFF: blend[i] = res[i].pix - res[i].hi;
        default:   blend[i] = res[i].lo;
      endcase
    end
  end

  // hold the word until it is taken
  always_ff @(posedge clk) begin
    if (out_en) begin
      out_r.pixel_out_red   <= blend[0];
      out_r.pixel_out_green <= blend[1];
      out_r.pixel_out_blue  <= blend[2];
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/linear_gradient_pixel_blend.sv
// Horizontal gradient blend: one pixel word in per clock, one word out per
// pixel, in order. Each of the three color lanes forms the exact gradient
// numerator start*(W-1) + column*(end-start) and divides it by W-1 in an
// eight-stage restoring divider, one quotient bit per stage; the divider
// depth sets the latency: the word passes eleven registers (product, sum,
// eight divide steps, output register) before out_valid rises. Throughput
// is one pixel per cycle while out_stall is low; bubbles in the pipeline
// are squeezed out when the output stalls. Columns past W-1 saturate, a
// width of 0 or 1 gives the start color, widths above MAX_WIDTH saturate.
// Write configuration only while no pixel is in flight.
module linear_gradient_pixel_blend import lgpb_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEN_W       = $clog2(MAX_WIDTH);
  localparam int RST_W_SAT   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_DEN     = RST_W_SAT - 1;
  localparam int RST_DEN_EFF = (RST_DEN == 0) ? 1 : RST_DEN;

  logic [PIX_W-1:0]  start_r [NUM_LANES];
  logic [PIX_W-1:0]  start_nxt [NUM_LANES];
  logic [PIX_W-1:0]  end_r [NUM_LANES];
  logic [PIX_W-1:0]  end_nxt [NUM_LANES];
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  den_eff_r, den_eff_nxt;
  logic [31:0]       w_sat, den_full;

  // width register is kept as its saturated denominator
  always_comb begin
    w_sat    = (32'(cfg_wdata) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(cfg_wdata);
    den_full = (w_sat == 32'd0) ? 32'd0 : w_sat - 32'd1;
  end

  // decode configuration writes
  always_comb begin
    start_nxt   = start_r;
    end_nxt     = end_r;
    mode_nxt    = mode_r;
    den_nxt     = den_r;
    den_eff_nxt = den_eff_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_RED:   start_nxt[0] = cfg_wdata[PIX_W-1:0];
        REG_START_GREEN: start_nxt[1] = cfg_wdata[PIX_W-1:0];
        REG_START_BLUE:  start_nxt[2] = cfg_wdata[PIX_W-1:0];
        REG_END_RED:     end_nxt[0]   = cfg_wdata[PIX_W-1:0];
        REG_END_GREEN:   end_nxt[1]   = cfg_wdata[PIX_W-1:0];
        REG_END_BLUE:    end_nxt[2]   = cfg_wdata[PIX_W-1:0];
        REG_BLEND_MODE:  mode_nxt     = cfg_wdata[MODE_W-1:0];
        REG_IMAGE_WIDTH: begin
          den_nxt     = DEN_W'(den_full);
          den_eff_nxt = (den_full == 32'd0) ? DEN_W'(1) : DEN_W'(den_full);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      mode_r    <= MODE_SET;
      den_r     <= DEN_W'(RST_DEN);
      den_eff_r <= DEN_W'(RST_DEN_EFF);
    end else begin
      start_r   <= start_nxt;
      end_r     <= end_nxt;
      mode_r    <= mode_nxt;
      den_r     <= den_nxt;
      den_eff_r <= den_eff_nxt;
    end
  end

  // saturate the column to the last one
  logic [DEN_W-1:0] col_sat;

  assign col_sat = (32'(in_data.column) > 32'(den_r)) ? den_r : DEN_W'(in_data.column);

  // pipeline control
  pipe_ctrl_t ctl;

  lgpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // one lane per color channel
  logic [PIX_W-1:0]            lane_pix [NUM_LANES];
  lane_res_t [NUM_LANES-1:0]   lane_res;

  assign lane_pix[0] = in_data.pixel_in_red;
  assign lane_pix[1] = in_data.pixel_in_green;
  assign lane_pix[2] = in_data.pixel_in_blue;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    lgpb_lane #(
      .DEN_W (DEN_W)
    ) u_lane (
      .clk        (clk),
      .stage_en   (ctl.stage_en),
      .grad_start (start_r[i]),
      .grad_stop  (end_r[i]),
      .den_eff    (den_eff_r),
      .col_sat    (col_sat),
      .pix_in     (lane_pix[i]),
      .res        (lane_res[i])
    );
  end

  // combine lanes and register the result word
  lgpb_merge u_merge (
    .clk      (clk),
    .out_en   (ctl.out_en),
    .mode     (mode_r),
    .res      (lane_res),
    .out_data (out_data)
  );

endmodule

// File: test/tb_linear_gradient_pixel_blend.sv
`timescale 1ns / 1ps

module tb_linear_gradient_pixel_blend;
  import lgpb_pkg::*;

  localparam int GRAD_MAX_W   = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_PIXELS = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // pixels waiting to be sent and blended words still owed by the block
  in_word_t  pix_pending[$];
  out_word_t blend_expect[$];

  // shadow copy of the gradient registers
  logic [PIX_W-1:0]      grad_start[NUM_LANES];
  logic [PIX_W-1:0]      grad_end[NUM_LANES];
  logic [MODE_W-1:0]     grad_mode;
  logic [CFG_DATA_W-1:0] grad_width;

  bit in_took = 1'b0;
  bit calm_run = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  linear_gradient_pixel_blend #(
    .MAX_WIDTH(GRAD_MAX_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // exact gradient value for one color lane, blended into the pixel byte
  function automatic logic [PIX_W-1:0] blend_lane(logic [PIX_W-1:0] s, logic [PIX_W-1:0] e,
                                                  logic [PIX_W-1:0] pix,
                                                  logic [COL_W-1:0] col_raw);
    longint w;
    longint den;
    longint col;
    longint num;
    longint lo;
    longint hi;
    w = grad_width;
    if (w > GRAD_MAX_W) w = GRAD_MAX_W;
    den = (w == 0) ? 0 : w - 1;
    col = col_raw;
    if (col > den) col = den;
    if (den == 0) begin
      lo = s;
      hi = s;
    end else begin
      num = longint'(s) * den + col * (longint'(e) - longint'(s));
      lo = num / den;
      hi = (num + den - 1) / den;
    end
    case (grad_mode)
      MODE_SUM:  return pix + lo[PIX_W-1:0];
      MODE_DIFF: return pix - hi[PIX_W-1:0];
      default:   return lo[PIX_W-1:0];
    endcase
  endfunction

  function automatic out_word_t blend_pixel(in_word_t w);
    out_word_t r;
    r.pixel_out_red   = blend_lane(grad_start[0], grad_end[0], w.pixel_in_red, w.column);
    r.pixel_out_green = blend_lane(grad_start[1], grad_end[1], w.pixel_in_green, w.column);
    r.pixel_out_blue  = blend_lane(grad_start[2], grad_end[2], w.pixel_in_blue, w.column);
    return r;
  endfunction

  task automatic check_lane(string lane, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, lane, want, got);
    end
  endtask

  // drive the next pixel word or hold the current one
  always @(negedge clk) begin : drive_pix
    logic go;
    if (rst_n && (!in_valid || in_took)) begin
      go = (pix_pending.size() != 0) && (calm_run || $urandom_range(99) >= 12);
      if (go) in_data <= pix_pending.pop_front();
      in_valid <= go;
    end
    out_stall <= !calm_run && ($urandom_range(99) < 12);
  end

  // track register writes, predict accepted pixels, check delivered words
  always @(posedge clk) begin : watch_pix
    out_word_t want;
    in_took = 1'b0;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        grad_start[i] = '0;
        grad_end[i] = '0;
      end
      grad_mode = MODE_SET;
      grad_width = CFG_DATA_W'(RESET_WIDTH);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_RED:   grad_start[0] = cfg_wdata[PIX_W-1:0];
          REG_START_GREEN: grad_start[1] = cfg_wdata[PIX_W-1:0];
          REG_START_BLUE:  grad_start[2] = cfg_wdata[PIX_W-1:0];
          REG_END_RED:     grad_end[0] = cfg_wdata[PIX_W-1:0];
          REG_END_GREEN:   grad_end[1] = cfg_wdata[PIX_W-1:0];
          REG_END_BLUE:    grad_end[2] = cfg_wdata[PIX_W-1:0];
          REG_BLEND_MODE:  grad_mode = cfg_wdata[MODE_W-1:0];
          REG_IMAGE_WIDTH: grad_width = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        blend_expect.push_back(blend_pixel(in_data));
      end
      if (out_valid && !out_stall) begin
        if (blend_expect.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none actual %h", $time, out_data);
        end else begin
          want = blend_expect.pop_front();
          check_lane("red", want.pixel_out_red, out_data.pixel_out_red);
          check_lane("green", want.pixel_out_green, out_data.pixel_out_green);
          check_lane("blue", want.pixel_out_blue, out_data.pixel_out_blue);
        end
      end
    end
  end

  // end the run if the handshakes stop moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_pixel(int col, int r, int g, int b);
    in_word_t w;
    w.column = COL_W'(col);
    w.pixel_in_red = PIX_W'(r);
    w.pixel_in_green = PIX_W'(g);
    w.pixel_in_blue = PIX_W'(b);
    pix_pending.push_back(w);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
  endtask

  // write every register, then release the port
  task automatic apply_config(int sr, int sg, int sb, int er, int eg, int eb, int mode, int w);
    write_reg(REG_START_RED, sr);
    write_reg(REG_START_GREEN, sg);
    write_reg(REG_START_BLUE, sb);
    write_reg(REG_END_RED, er);
    write_reg(REG_END_GREEN, eg);
    write_reg(REG_END_BLUE, eb);
    write_reg(REG_BLEND_MODE, mode);
    write_reg(REG_IMAGE_WIDTH, w);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every sent pixel has come back, then let the pipeline settle
  task automatic drain_pipe();
    while (pix_pending.size() != 0 || in_valid || blend_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_color();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return 255;
    return $urandom_range(255);
  endfunction

  initial begin : run_blend
    int widths[8];
    int w;
    int den;
    int col;
    int r;
    widths = '{0, 1, 2, 3, 4095, 4096, 4097, 8191};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: flat black gradient, column saturation
    push_pixel(0, 0, 0, 0);
    push_pixel(4095, 255, 255, 255);
    drain_pipe();

    // full-width ramps in set mode
    apply_config(0, 255, 17, 255, 0, 200, MODE_SET, 4096);
    push_pixel(0, 1, 2, 3);
    push_pixel(1, 4, 5, 6);
    push_pixel(2047, 7, 8, 9);
    push_pixel(4095, 10, 11, 12);
    drain_pipe();

    // single column width gives the start color; add wraps
    apply_config(0, 255, 17, 255, 0, 200, MODE_SUM, 1);
    push_pixel(0, 255, 255, 255);
    push_pixel(4095, 200, 200, 200);
    drain_pipe();

    // zero width, subtract
    apply_config(0, 255, 17, 255, 0, 200, MODE_DIFF, 0);
    push_pixel(5, 0, 0, 0);
    drain_pipe();

    // unused mode code behaves as set
    apply_config(3, 250, 100, 200, 0, 101, 3, 2);
    push_pixel(0, 9, 9, 9);
    push_pixel(1, 9, 9, 9);
    push_pixel(2, 9, 9, 9);
    drain_pipe();

    // width above the maximum saturates; subtract uses the ceiling
    apply_config(1, 254, 77, 254, 1, 78, MODE_DIFF, 8191);
    push_pixel(4095, 0, 0, 0);
    push_pixel(1, 0, 0, 0);
    push_pixel(3000, 0, 0, 0);
    drain_pipe();

    // fractional steps where floor and ceiling differ
    apply_config(255, 0, 128, 0, 255, 129, MODE_SUM, 3);
    push_pixel(0, 128, 128, 128);
    push_pixel(1, 128, 128, 128);
    push_pixel(2, 128, 128, 128);
    drain_pipe();

    // random gradients, one setting per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r = $urandom_range(99);
      if (r < 15) w = widths[$urandom_range(7)];
      else if (r < 60) w = $urandom_range(2, 64);
      else w = $urandom_range(0, 8191);
      apply_config(pick_color(), pick_color(), pick_color(), pick_color(), pick_color(),
                   pick_color(), $urandom_range(3), w);
      calm_run = (ph == 4);
      if (w > GRAD_MAX_W) w = GRAD_MAX_W;
      den = (w == 0) ? 0 : w - 1;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        r = $urandom_range(99);
        if (r < 70) col = $urandom_range(den);
        else if (r < 80) col = (den + $urandom_range(1) > 4095) ? 4095 : den + $urandom_range(1);
        else col = $urandom_range(4095);
        push_pixel(col, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      end
      drain_pipe();
      calm_run = 1'b0;
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: linear_gradient_pixel_blend.f
+incdir+rtl/core
rtl/core/lgpb_pkg.sv
rtl/core/lgpb_ctrl.sv
rtl/core/lgpb_lane.sv
rtl/core/lgpb_merge.sv
rtl/core/linear_gradient_pixel_blend.sv
test/tb_linear_gradient_pixel_blend.sv
